>>> hdl/pcu_pkg.sv
// ---------------------------------------------------------------------------
// pcu_pkg
// Shared types and codes for the match-based PWM channel.
// ---------------------------------------------------------------------------
`default_nettype none

package pcu_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_INIT       = 2'd1,
        FUNC_IMM_UPDATE = 2'd2,
        FUNC_COH_UPDATE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        EVT_NONE = 2'd0,
        EVT_RISE = 2'd1,
        EVT_FALL = 2'd2
    } evt_t;

endpackage

`default_nettype wire

>>> hdl/pcu_ifs.sv
// ---------------------------------------------------------------------------
// pcu_ifs
// Command and status channels of the PWM channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pcu_cmd_if #(
    parameter int TIME_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] active_time;

    modport source (output valid, func, period, active_time, input ready);
    modport sink   (input valid, func, period, active_time, output ready);
endinterface

interface pcu_stat_if;
    logic       valid;
    logic       ready;
    logic       pin_level;
    logic       in_active_phase;
    logic [1:0] edge_event;

    modport source (output valid, pin_level, in_active_phase, edge_event, input ready);
    modport sink   (input valid, pin_level, in_active_phase, edge_event, output ready);
endinterface

`default_nettype wire

>>> hdl/pwm_channel_with_coherent_update.sv
// ---------------------------------------------------------------------------
// pwm_channel_with_coherent_update
// PWM channel on a wrapping time counter with rise and fall match times,
// immediate and coherent period/active-time update.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  cmd      | in  | func, period, active_time                 | valid/ready
//  stat     | out | pin_level, in_active_phase, edge_event    | valid/ready
//  cfg      | in  | cfg_wdata (active_high)                   | cfg_we
//
//  One item per clock sustained while results are not stalled.
//  Stage one registers the item, stage two applies it to the channel state
//  and registers the result.
//  A stalled result holds stage two; stage one then fills and cmd.ready drops.
//  Reset clears counter, match times, pin/run flags; expect_rise, polarity go to 1.
// ---------------------------------------------------------------------------
`default_nettype none

module pwm_channel_with_coherent_update
    import pcu_pkg::*;
#(
    parameter int TIME_BITS = 24
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pcu_cmd_if.sink       cmd,
    pcu_stat_if.source    stat,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    typedef logic [TIME_BITS-1:0] tval_t;

    logic  cfg_active_high_reg;

    logic  s1_valid_reg;
    func_t s1_func_reg;
    tval_t s1_period_reg;
    tval_t s1_active_reg;

    logic  out_valid_reg;
    logic  out_pin_reg;
    logic  out_phase_reg;
    evt_t  out_evt_reg;

    tval_t time_count_reg,  time_count_next;
    tval_t rise_match_reg,  rise_match_next;
    tval_t fall_match_reg,  fall_match_next;
    tval_t frame_start_reg, frame_start_next;
    tval_t next_fall_reg,   next_fall_next;
    tval_t cur_period_reg,  cur_period_next;
    tval_t cur_active_reg,  cur_active_next;
    logic  rise_pin_active_reg, rise_pin_active_next;
    logic  expect_rise_reg,     expect_rise_next;
    logic  pin_out_reg,         pin_out_next;
    logic  running_reg,         running_next;
    logic  pol_high_reg,        pol_high_next;
    evt_t  evt_next;

    logic  advance;
    tval_t count_inc;
    tval_t rise_diff;
    tval_t fall_diff;
    tval_t rise_sum;
    tval_t upd_fall;

    assign advance   = s1_valid_reg && (!out_valid_reg || stat.ready);
    assign cmd.ready = !s1_valid_reg || advance;

    assign count_inc = time_count_reg + tval_t'(1);
    assign rise_diff = count_inc - rise_match_reg;
    assign fall_diff = count_inc - fall_match_reg;
    assign rise_sum  = rise_match_reg + cur_period_reg;
    assign upd_fall  = frame_start_reg + s1_active_reg;

    always_comb
    begin
        time_count_next      = time_count_reg;
        rise_match_next      = rise_match_reg;
        fall_match_next      = fall_match_reg;
        frame_start_next     = frame_start_reg;
        next_fall_next       = next_fall_reg;
        cur_period_next      = cur_period_reg;
        cur_active_next      = cur_active_reg;
        rise_pin_active_next = rise_pin_active_reg;
        expect_rise_next     = expect_rise_reg;
        pin_out_next         = pin_out_reg;
        running_next         = running_reg;
        pol_high_next        = pol_high_reg;
        evt_next             = EVT_NONE;

        unique case (s1_func_reg)
            FUNC_TICK:
            begin
                time_count_next = count_inc;
                if (running_reg)
                begin
                    if (expect_rise_reg)
                    begin
                        if (!rise_diff[TIME_BITS-1])
                        begin
                            pin_out_next         = rise_pin_active_reg ? pol_high_reg
                                                                       : !pol_high_reg;
                            rise_pin_active_next = (cur_active_reg != '0);
                            rise_match_next      = rise_sum;
                            frame_start_next     = rise_sum;
                            next_fall_next       = rise_sum + cur_active_reg;
                            expect_rise_next     = 1'b0;
                            evt_next             = EVT_RISE;
                        end
                    end
                    else if (!fall_diff[TIME_BITS-1])
                    begin
                        pin_out_next     = !pol_high_reg;
                        fall_match_next  = next_fall_reg;
                        expect_rise_next = 1'b1;
                        evt_next         = EVT_FALL;
                    end
                end
            end
            FUNC_INIT:
            begin
                cur_period_next      = s1_period_reg;
                cur_active_next      = s1_active_reg;
                pol_high_next        = cfg_active_high_reg;
                rise_match_next      = count_inc;
                fall_match_next      = count_inc + s1_active_reg;
                frame_start_next     = count_inc;
                next_fall_next       = count_inc + s1_active_reg;
                rise_pin_active_next = (s1_active_reg != '0);
                pin_out_next         = !cfg_active_high_reg;
                expect_rise_next     = 1'b1;
                running_next         = 1'b1;
            end
            FUNC_IMM_UPDATE:
            begin
                cur_period_next = s1_period_reg;
                cur_active_next = s1_active_reg;
                next_fall_next  = upd_fall;
                fall_match_next = expect_rise_reg ? upd_fall : upd_fall - s1_period_reg;
            end
            FUNC_COH_UPDATE:
            begin
                cur_period_next = s1_period_reg;
                cur_active_next = s1_active_reg;
                next_fall_next  = upd_fall;
                if (expect_rise_reg)
                begin
                    fall_match_next = upd_fall;
                end
            end
            default:
            begin
                evt_next = EVT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_active_high_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            cfg_active_high_reg <= cfg_wdata;
        end
    end

    // stage one: hold the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_func_reg   <= func_t'(cmd.func);
            s1_period_reg <= cmd.period;
            s1_active_reg <= cmd.active_time;
        end
    end

    // stage two: advance channel state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg      <= '0;
            rise_match_reg      <= '0;
            fall_match_reg      <= '0;
            frame_start_reg     <= '0;
            next_fall_reg       <= '0;
            cur_period_reg      <= '0;
            cur_active_reg      <= '0;
            rise_pin_active_reg <= 1'b0;
            expect_rise_reg     <= 1'b1;
            pin_out_reg         <= 1'b0;
            running_reg         <= 1'b0;
            pol_high_reg        <= 1'b1;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                time_count_reg      <= time_count_next;
                rise_match_reg      <= rise_match_next;
                fall_match_reg      <= fall_match_next;
                frame_start_reg     <= frame_start_next;
                next_fall_reg       <= next_fall_next;
                cur_period_reg      <= cur_period_next;
                cur_active_reg      <= cur_active_next;
                rise_pin_active_reg <= rise_pin_active_next;
                expect_rise_reg     <= expect_rise_next;
                pin_out_reg         <= pin_out_next;
                running_reg         <= running_next;
                pol_high_reg        <= pol_high_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stat.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pin_reg   <= pin_out_next;
            out_phase_reg <= !expect_rise_next;
            out_evt_reg   <= evt_next;
        end
    end

    assign stat.valid           = out_valid_reg;
    assign stat.pin_level       = out_pin_reg;
    assign stat.in_active_phase = out_phase_reg;
    assign stat.edge_event      = out_evt_reg;

    a_rise_enters_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_evt_reg == EVT_RISE |-> out_phase_reg)
        else $error("rise result outside active phase");

    a_fall_leaves_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_evt_reg == EVT_FALL |-> !out_phase_reg)
        else $error("fall result inside active phase");

    a_idle_waits_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> expect_rise_reg)
        else $error("active phase before init");

    a_non_tick_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_func_reg != FUNC_TICK |=> out_evt_reg == EVT_NONE)
        else $error("edge reported for non-tick item");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> out_valid_reg && !stat.ready)
        else $error("input blocked without output stall");

endmodule

`default_nettype wire

>>> sim/pwm_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pwm_checker
// Watches the command, status and configuration ports of the PWM channel,
// keeps its own copy of the channel state to work out the status of every
// accepted command item, and compares each status item against the oldest
// outstanding one.
// ---------------------------------------------------------------------------
module pwm_checker
    import pcu_pkg::*;
#(
    parameter int TIME_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pcu_cmd_if        cmd,
    pcu_stat_if       stat,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    output int        fail_count,
    output int        pending
);

    typedef logic [TIME_BITS-1:0] tick_t;

    typedef struct packed {
        logic pin_level;
        logic in_active_phase;
        evt_t edge_event;
    } status_t;

    status_t status_due[$];

    tick_t time_count;
    tick_t rise_match;
    tick_t fall_match;
    tick_t frame_start;
    tick_t next_fall;
    tick_t cur_period;
    tick_t cur_active;
    logic  rise_drives_active;
    logic  wait_rise;
    logic  pin_out;
    logic  running;
    logic  pol_high;
    logic  active_high_reg;
    int    reported;

    function automatic logic reached(tick_t target);
        tick_t distance;
        distance = time_count - target;
        return ~distance[TIME_BITS-1];
    endfunction

    function automatic status_t apply_command(func_t f, tick_t per, tick_t act);
        status_t res;
        evt_t    evt;
        evt = EVT_NONE;
        case (f)
            FUNC_TICK:
            begin
                time_count = time_count + tick_t'(1);
                if (running)
                begin
                    if (wait_rise)
                    begin
                        if (reached(rise_match))
                        begin
                            pin_out            = rise_drives_active ? pol_high : ~pol_high;
                            rise_drives_active = (cur_active != '0);
                            rise_match         = rise_match + cur_period;
                            frame_start        = rise_match;
                            next_fall          = rise_match + cur_active;
                            wait_rise          = 1'b0;
                            evt                = EVT_RISE;
                        end
                    end
                    else if (reached(fall_match))
                    begin
                        pin_out    = ~pol_high;
                        fall_match = next_fall;
                        wait_rise  = 1'b1;
                        evt        = EVT_FALL;
                    end
                end
            end
            FUNC_INIT:
            begin
                cur_period         = per;
                cur_active         = act;
                pol_high           = active_high_reg;
                rise_match         = time_count + tick_t'(1);
                fall_match         = rise_match + act;
                frame_start        = rise_match;
                next_fall          = fall_match;
                rise_drives_active = (act != '0);
                pin_out            = ~pol_high;
                wait_rise          = 1'b1;
                running            = 1'b1;
            end
            FUNC_IMM_UPDATE:
            begin
                cur_period = per;
                cur_active = act;
                next_fall  = frame_start + act;
                fall_match = wait_rise ? next_fall : next_fall - per;
            end
            default:
            begin
                next_fall = frame_start + act;
                if (wait_rise)
                    fall_match = next_fall;
                cur_period = per;
                cur_active = act;
            end
        endcase
        res.pin_level       = pin_out;
        res.in_active_phase = ~wait_rise;
        res.edge_event      = evt;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            time_count         = '0;
            rise_match         = '0;
            fall_match         = '0;
            frame_start        = '0;
            next_fall          = '0;
            cur_period         = '0;
            cur_active         = '0;
            rise_drives_active = 1'b0;
            wait_rise          = 1'b1;
            pin_out            = 1'b0;
            running            = 1'b0;
            pol_high           = 1'b1;
            active_high_reg    = 1'b1;
            status_due.delete();
            fail_count         = 0;
            pending            = 0;
            reported           = 0;
        end
        else
        begin
            if (stat.valid && stat.ready)
            begin
                got.pin_level       = stat.pin_level;
                got.in_active_phase = stat.in_active_phase;
                got.edge_event      = evt_t'(stat.edge_event);
                if (status_due.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("%0t: status item with none outstanding: pin %b active %b evt %0d",
                                 $realtime, got.pin_level, got.in_active_phase, got.edge_event);
                    reported++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.pin_level !== want.pin_level
                        || got.in_active_phase !== want.in_active_phase
                        || got.edge_event !== want.edge_event)
                    begin
                        fail_count++;
                        if (reported < 10)
                            $display("%0t: status mismatch: pin %b/%b active %b/%b evt %0d/%0d",
                                     $realtime, want.pin_level, got.pin_level,
                                     want.in_active_phase, got.in_active_phase,
                                     want.edge_event, got.edge_event);
                        reported++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                status_due.push_back(apply_command(func_t'(cmd.func), cmd.period,
                                                   cmd.active_time));
            if (cfg_we)
                active_high_reg = cfg_wdata;
            pending = status_due.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the PWM channel with a short directed run and then with random
// init/tick/update sequences under random stalls on both channels and
// polarity changes between phases; the checker module judges every status
// item.
// ---------------------------------------------------------------------------
module testbench;
    import pcu_pkg::*;

    localparam int TIME_BITS  = 24;
    localparam int RAND_ITEMS = 650;
    localparam int LIMIT      = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic no_idle;
    int   fail_count;
    int   pending;
    int   cycle_count;

    pcu_cmd_if #(.TIME_BITS(TIME_BITS)) cmd_ch ();
    pcu_stat_if                         stat_ch ();

    pwm_channel_with_coherent_update #(.TIME_BITS(TIME_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .stat      (stat_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pwm_checker #(.TIME_BITS(TIME_BITS)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .stat       (stat_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_word();
        return TIME_BITS'($urandom);
    endfunction

    task automatic send_cmd(func_t f, logic [TIME_BITS-1:0] per,
                            logic [TIME_BITS-1:0] act);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid       = 1'b1;
        cmd_ch.func        = f;
        cmd_ch.period      = per;
        cmd_ch.active_time = act;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_cmd(FUNC_TICK, rand_word(), rand_word());
    endtask

    task automatic write_polarity(logic value);
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int gap;
        stat_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                stat_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            stat_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!stat_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int                   sent;
        int                   len;
        int                   r;
        logic [TIME_BITS-1:0] per;
        logic [TIME_BITS-1:0] act;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b1;
        no_idle            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.func        = FUNC_TICK;
        cmd_ch.period      = '0;
        cmd_ch.active_time = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // before init: ticks only count, updates still land
        send_cmd(FUNC_TICK, '1, '1);
        send_cmd(FUNC_IMM_UPDATE, 24'd5, 24'd3);
        send_cmd(FUNC_COH_UPDATE, 24'd6, 24'd2);
        send_cmd(FUNC_INIT, 24'd4, 24'd2);
        send_ticks(5);
        send_cmd(FUNC_IMM_UPDATE, 24'd5, 24'd4);
        send_ticks(3);
        send_cmd(FUNC_COH_UPDATE, 24'd3, 24'd0);
        send_ticks(5);
        write_polarity(1'b0);
        send_cmd(FUNC_INIT, '1, '1);
        send_ticks(2);
        send_cmd(FUNC_INIT, '0, '0);
        send_ticks(2);
        write_polarity(1'b1);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_polarity(1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            per = TIME_BITS'($urandom_range(1, 16));
            act = TIME_BITS'($urandom_range(0, 32'(per)));
            send_cmd(FUNC_INIT, per, act);
            sent++;
            len = $urandom_range(10, 50);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                per = TIME_BITS'($urandom_range(1, 16));
                act = TIME_BITS'($urandom_range(0, 32'(per)));
                if (r < 70)
                    send_cmd(FUNC_TICK, rand_word(), rand_word());
                else if (r < 80)
                    send_cmd(FUNC_IMM_UPDATE, per, act);
                else if (r < 90)
                    send_cmd(FUNC_COH_UPDATE, per, act);
                else if (r < 95)
                    send_cmd(func_t'($urandom_range(0, 3)), rand_word(), rand_word());
                else
                    send_cmd(FUNC_INIT, per, act);
                sent++;
            end
            no_idle = 1'b0;
        end

        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> pwm_channel_with_coherent_update.f
hdl/pcu_pkg.sv
hdl/pcu_ifs.sv
hdl/pwm_channel_with_coherent_update.sv
sim/pwm_checker.sv
sim/testbench.sv
